[rtl/logistic_map_period_detector_unit_macros.svh]
// Assertion macros for the checker in lmpd_chk.sv.
`ifndef LOGISTIC_MAP_PERIOD_DETECTOR_UNIT_MACROS_SVH
`define LOGISTIC_MAP_PERIOD_DETECTOR_UNIT_MACROS_SVH

// Check a property outside reset.
`define LMPD_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check a property at every edge, reset included.
`define LMPD_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

[rtl/lmpd_pkg.sv]
package lmpd_pkg;

    localparam int MAX_SAMPLES = 1024;
    localparam int ADDR_W      = $clog2(MAX_SAMPLES);
    localparam int CNT_W       = $clog2(MAX_SAMPLES + 1);

    localparam int X_W    = 32;
    localparam int CEIL_W = 7;
    localparam int STEP_W = 20;
    localparam int SCNT_W = 11;
    localparam int GAP_W  = 32;
    localparam int PADDR_W = 4;

    localparam logic [X_W-1:0] X_HALF = 32'h8000_0000;

    localparam logic [CEIL_W-1:0] CEIL_RST = 7'd64;
    localparam logic [STEP_W-1:0] STEP_RST = 20'd20000;
    localparam logic [SCNT_W-1:0] SCNT_RST = 11'd1024;
    localparam logic [GAP_W-1:0]  GAP_RST  = 32'd429497;

    typedef enum logic [1:0] {
        REG_PERIOD_CEILING = 2'd0,
        REG_SETTLE_STEPS   = 2'd1,
        REG_SAMPLE_COUNT   = 2'd2,
        REG_CLUSTER_GAP    = 2'd3
    } t_reg_idx;

    typedef struct packed {
        logic [CEIL_W-1:0] period_ceiling;
        logic [STEP_W-1:0] settle_steps;
        logic [SCNT_W-1:0] sample_count;
        logic [GAP_W-1:0]  cluster_gap;
    } t_cfg;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_STEP_CHK,
        ST_MUL_A,
        ST_MUL_B,
        ST_MUL_C,
        ST_INS_CHK,
        ST_INS_CMP,
        ST_CNT_RD,
        ST_CNT_TAKE,
        ST_OUT
    } t_state;

endpackage

[rtl/lmpd_if.sv]
interface lmpd_in_if;
    logic        valid;
    logic        ready;
    logic [31:0] growth_rate;
    modport source (output valid, output growth_rate, input ready);
    modport sink   (input valid, input growth_rate, output ready);
endinterface

interface lmpd_out_if;
    logic       valid;
    logic       ready;
    logic [6:0] orbit_period;
    modport source (output valid, output orbit_period, input ready);
    modport sink   (input valid, input orbit_period, output ready);
endinterface

[rtl/logistic_map_period_detector_unit.sv]
// Logistic map period detector.
// i_in carries one item, the growth rate r (unsigned Q2.30); o_out returns
// one item per input, the orbit period (0 when above the period ceiling).
// Registers are to be written over the APB port only while the block is
// idle; the block itself does not enforce this. The block takes one item at
// a time: i_in.ready is high only while idle. Each map step is a loop check,
// then two products on the one shared 33x32 multiplier and a saturating
// update. An item takes settle_steps + n map steps, with n = sample_count
// (capped at the store depth). Samples are placed in order as they arrive
// by insertion into a single-port-read RAM, shifting each larger entry up
// by one. Cluster counting reads the store once. The result sits in an
// output register; the block returns to idle as soon as it is loaded, so
// the next item is taken while o_out stalls. A further result waits in the
// sequencer until the register is free. Reset (synchronous, active low)
// restores register defaults and empties the output register; the sample
// store needs no clearing.
module logistic_map_period_detector_unit (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    lmpd_in_if.sink                       i_in,
    lmpd_out_if.source                    o_out,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [lmpd_pkg::PADDR_W-1:0]  paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready
);
    import lmpd_pkg::*;

    t_cfg   w_cfg;
    t_state r_state, n_state;

    logic [X_W-1:0]    r_x, n_x;
    logic [X_W-1:0]    r_r, n_r;
    logic [X_W-1:0]    r_v, n_v;
    logic [X_W-1:0]    r_prev, n_prev;
    logic [STEP_W-1:0] r_step, n_step;
    logic [CNT_W-1:0]  r_i, n_i;
    logic [CNT_W-1:0]  r_n, n_n;
    logic [CNT_W-1:0]  r_k, n_k;
    logic [CNT_W-1:0]  r_clu, n_clu;
    logic [ADDR_W-1:0] r_j, n_j;
    logic              r_ovalid, n_ovalid;
    logic [6:0]        r_operiod, n_operiod;

    logic [32:0]       w_ma;
    logic [31:0]       w_mb;
    logic [64:0]       w_prod;
    logic [34:0]       w_nx;
    logic [X_W-1:0]    w_nx_sat;

    logic              w_we;
    logic [ADDR_W-1:0] w_waddr, w_raddr;
    logic [X_W-1:0]    w_wdata, w_rdata;

    lmpd_apb u_apb (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    lmpd_mul u_mul (
        .i_clk  (i_clk),
        .i_a    (w_ma),
        .i_b    (w_mb),
        .o_prod (w_prod)
    );

    lmpd_ram #(.WIDTH(X_W), .DEPTH(MAX_SAMPLES)) u_store (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    // Map update: second product shifted down, saturated at one
    assign w_nx     = w_prod[64:30];
    assign w_nx_sat = (|w_nx[34:32]) ? {X_W{1'b1}} : w_nx[31:0];

    assign i_in.ready         = (r_state == ST_IDLE);
    assign o_out.valid        = r_ovalid;
    assign o_out.orbit_period = r_operiod;

    // Hold control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_ovalid <= n_ovalid;
        end
    end

    // Hold datapath registers
    always_ff @(posedge i_clk) begin
        r_x       <= n_x;
        r_r       <= n_r;
        r_v       <= n_v;
        r_prev    <= n_prev;
        r_step    <= n_step;
        r_i       <= n_i;
        r_n       <= n_n;
        r_k       <= n_k;
        r_clu     <= n_clu;
        r_j       <= n_j;
        r_operiod <= n_operiod;
    end

    // Sequence the map steps, insertion and cluster count
    always_comb begin
        n_state   = r_state;
        n_x       = r_x;
        n_r       = r_r;
        n_v       = r_v;
        n_prev    = r_prev;
        n_step    = r_step;
        n_i       = r_i;
        n_n       = r_n;
        n_k       = r_k;
        n_clu     = r_clu;
        n_j       = r_j;
        n_operiod = r_operiod;
        n_ovalid  = r_ovalid;
        w_ma      = 33'h1_0000_0000 - {1'b0, r_x};
        w_mb      = r_x;
        w_we      = 1'b0;
        w_waddr   = r_j;
        w_wdata   = r_v;
        w_raddr   = r_j - ADDR_W'(1);

        // Drop the result once taken
        if (o_out.ready) begin
            n_ovalid = 1'b0;
        end

        case (r_state)
            ST_IDLE: begin
                if (i_in.valid) begin
                    n_r    = i_in.growth_rate;
                    n_x    = X_HALF;
                    n_step = '0;
                    n_i    = '0;
                    if (32'(w_cfg.sample_count) > 32'(MAX_SAMPLES)) begin
                        n_n = CNT_W'(MAX_SAMPLES);
                    end else begin
                        n_n = CNT_W'(w_cfg.sample_count);
                    end
                    n_state = ST_STEP_CHK;
                end
            end
            ST_STEP_CHK: begin
                if (r_step < w_cfg.settle_steps || r_i < r_n) begin
                    n_state = ST_MUL_A;
                end else begin
                    n_k     = '0;
                    n_clu   = CNT_W'(1);
                    n_state = ST_CNT_RD;
                end
            end
            ST_MUL_A: begin
                // x * (1 - x) issued by default operands
                n_state = ST_MUL_B;
            end
            ST_MUL_B: begin
                w_ma    = {2'b00, w_prod[62:32]};
                w_mb    = r_r;
                n_state = ST_MUL_C;
            end
            ST_MUL_C: begin
                n_x = w_nx_sat;
                if (r_step < w_cfg.settle_steps) begin
                    n_step  = r_step + STEP_W'(1);
                    n_state = ST_STEP_CHK;
                end else begin
                    n_v     = w_nx_sat;
                    n_j     = r_i[ADDR_W-1:0];
                    n_state = ST_INS_CHK;
                end
            end
            ST_INS_CHK: begin
                if (r_j == '0) begin
                    w_we    = 1'b1;
                    n_i     = r_i + CNT_W'(1);
                    n_state = ST_STEP_CHK;
                end else begin
                    n_state = ST_INS_CMP;
                end
            end
            ST_INS_CMP: begin
                // Shift the larger neighbour up, or place the sample
                w_we = 1'b1;
                if (w_rdata > r_v) begin
                    w_wdata = w_rdata;
                    n_j     = r_j - ADDR_W'(1);
                    n_state = ST_INS_CHK;
                end else begin
                    n_i     = r_i + CNT_W'(1);
                    n_state = ST_STEP_CHK;
                end
            end
            ST_CNT_RD: begin
                w_raddr = r_k[ADDR_W-1:0];
                if (r_k == r_n) begin
                    n_state = ST_OUT;
                end else begin
                    n_state = ST_CNT_TAKE;
                end
            end
            ST_CNT_TAKE: begin
                if (r_k != '0 && (w_rdata - r_prev) > w_cfg.cluster_gap) begin
                    n_clu = r_clu + CNT_W'(1);
                end
                n_prev  = w_rdata;
                n_k     = r_k + CNT_W'(1);
                n_state = ST_CNT_RD;
            end
            ST_OUT: begin
                // Load the output register when it is free
                if (!r_ovalid || o_out.ready) begin
                    n_ovalid = 1'b1;
                    if (32'(r_clu) > 32'(w_cfg.period_ceiling)) begin
                        n_operiod = '0;
                    end else begin
                        n_operiod = 7'(r_clu);
                    end
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end
endmodule

[rtl/lmpd_ram.sv]
module lmpd_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write one entry, read one entry into a register
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

[rtl/lmpd_mul.sv]
module lmpd_mul (
    input  logic        i_clk,
    input  logic [32:0] i_a,
    input  logic [31:0] i_b,
    output logic [64:0] o_prod
);
    // Register the product of the shared multiplier
    always_ff @(posedge i_clk) begin
        o_prod <= 65'(i_a) * 65'(i_b);
    end
endmodule

[rtl/lmpd_apb.sv]
module lmpd_apb (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [lmpd_pkg::PADDR_W-1:0]  paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready,
    output lmpd_pkg::t_cfg                o_cfg
);
    import lmpd_pkg::*;

    t_cfg     r_cfg;
    t_reg_idx w_idx;
    logic     w_wr;

    assign w_idx  = t_reg_idx'(paddr[3:2]);
    assign w_wr   = psel && penable && pwrite;
    assign pready = 1'b1;
    assign o_cfg  = r_cfg;

    // Update the addressed register on the access cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.period_ceiling <= CEIL_RST;
            r_cfg.settle_steps   <= STEP_RST;
            r_cfg.sample_count   <= SCNT_RST;
            r_cfg.cluster_gap    <= GAP_RST;
        end else if (w_wr) begin
            case (w_idx)
                REG_PERIOD_CEILING: r_cfg.period_ceiling <= pwdata[CEIL_W-1:0];
                REG_SETTLE_STEPS:   r_cfg.settle_steps   <= pwdata[STEP_W-1:0];
                REG_SAMPLE_COUNT:   r_cfg.sample_count   <= pwdata[SCNT_W-1:0];
                REG_CLUSTER_GAP:    r_cfg.cluster_gap    <= pwdata[GAP_W-1:0];
                default: ;
            endcase
        end
    end

    // Return the addressed register
    always_comb begin
        case (w_idx)
            REG_PERIOD_CEILING: prdata = 32'(r_cfg.period_ceiling);
            REG_SETTLE_STEPS:   prdata = 32'(r_cfg.settle_steps);
            REG_SAMPLE_COUNT:   prdata = 32'(r_cfg.sample_count);
            REG_CLUSTER_GAP:    prdata = r_cfg.cluster_gap;
            default:            prdata = '0;
        endcase
    end
endmodule

[rtl/lmpd_chk.sv]
module lmpd_chk (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_in_valid,
    input logic       i_in_ready,
    input logic       i_out_valid,
    input logic       i_out_ready,
    input logic [6:0] i_out_period
);
    `include "logistic_map_period_detector_unit_macros.svh"

    `LMPD_ASSERT(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready |=> i_out_valid, "result dropped while stalled")
    `LMPD_ASSERT(a_out_stable, i_clk, i_rst_n, i_out_valid && !i_out_ready |=> $stable(i_out_period), "stalled result changed")
    `LMPD_ASSERT(a_busy_after_accept, i_clk, i_rst_n, i_in_valid && i_in_ready |=> !i_in_ready, "item taken while busy")
    `LMPD_ASSERT_ALWAYS(a_reset_idle, i_clk, !i_rst_n |=> i_in_ready && !i_out_valid, "not idle after reset")
endmodule

bind logistic_map_period_detector_unit lmpd_chk u_lmpd_chk (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_in.valid),
    .i_in_ready   (i_in.ready),
    .i_out_valid  (o_out.valid),
    .i_out_ready  (o_out.ready),
    .i_out_period (o_out.orbit_period)
);

[tb/sv/lmpd_checker.sv]
`timescale 1ns / 1ps

module lmpd_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    lmpd_in_if          i_in_mon,
    lmpd_out_if         i_out_mon,
    input  logic        i_psel,
    input  logic        i_penable,
    input  logic        i_pwrite,
    input  logic        i_pready,
    input  logic [lmpd_pkg::PADDR_W-1:0] i_paddr,
    input  logic [31:0] i_pwdata,
    output int          o_fail_count,
    output int          o_pending
);
    import lmpd_pkg::*;

    // Local copy of the register file
    logic [CEIL_W-1:0] period_ceiling;
    logic [STEP_W-1:0] settle_steps;
    logic [SCNT_W-1:0] sample_count;
    logic [GAP_W-1:0]  cluster_gap;

    logic [6:0] expected_periods[$];

    // One fixed-point map step with saturation at one
    function automatic logic [31:0] next_orbit(logic [31:0] x, logic [31:0] r);
        logic [63:0] one_minus;
        logic [63:0] q;
        logic [63:0] nx;
        one_minus = 64'h1_0000_0000 - {32'd0, x};
        q  = ({32'd0, x} * one_minus) >> 32;
        nx = ({32'd0, r} * q) >> 30;
        if (nx > 64'h0000_0000_FFFF_FFFF) begin
            nx = 64'h0000_0000_FFFF_FFFF;
        end
        return nx[31:0];
    endfunction

    // Settle, sample, sort and count clusters for one growth rate
    function automatic logic [6:0] predict_period(logic [31:0] r);
        logic [31:0] orbit_samples[MAX_SAMPLES];
        logic [31:0] x;
        logic [31:0] v;
        int n;
        int j;
        int clusters;
        n = (sample_count > MAX_SAMPLES) ? MAX_SAMPLES : int'(sample_count);
        x = X_HALF;
        for (int i = 0; i < int'(settle_steps); i++) begin
            x = next_orbit(x, r);
        end
        for (int i = 0; i < n; i++) begin
            x = next_orbit(x, r);
            orbit_samples[i] = x;
        end
        for (int i = 1; i < n; i++) begin
            v = orbit_samples[i];
            j = i;
            while (j > 0 && orbit_samples[j-1] > v) begin
                orbit_samples[j] = orbit_samples[j-1];
                j--;
            end
            orbit_samples[j] = v;
        end
        clusters = 1;
        for (int i = 1; i < n; i++) begin
            if (orbit_samples[i] - orbit_samples[i-1] > cluster_gap) begin
                clusters++;
            end
        end
        return (clusters > int'(period_ceiling)) ? 7'd0 : clusters[6:0];
    endfunction

    task automatic report_mismatch(input string what);
        $display("%0t mismatch: %s", $realtime, what);
        o_fail_count++;
    endtask

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
    end

    // Track register writes, predict on each accepted item, compare results
    always @(posedge i_clk) begin
        logic [6:0] want;
        if (!i_rst_n) begin
            period_ceiling <= CEIL_RST;
            settle_steps   <= STEP_RST;
            sample_count   <= SCNT_RST;
            cluster_gap    <= GAP_RST;
        end else begin
            if (i_psel && i_penable && i_pwrite && i_pready) begin
                case (t_reg_idx'(i_paddr[3:2]))
                    REG_PERIOD_CEILING: period_ceiling <= i_pwdata[CEIL_W-1:0];
                    REG_SETTLE_STEPS:   settle_steps   <= i_pwdata[STEP_W-1:0];
                    REG_SAMPLE_COUNT:   sample_count   <= i_pwdata[SCNT_W-1:0];
                    REG_CLUSTER_GAP:    cluster_gap    <= i_pwdata[GAP_W-1:0];
                    default: ;
                endcase
            end
            if (i_out_mon.valid && i_out_mon.ready) begin
                if (expected_periods.size() == 0) begin
                    report_mismatch($sformatf("unexpected period %0d",
                                              i_out_mon.orbit_period));
                end else begin
                    want = expected_periods.pop_front();
                    if (i_out_mon.orbit_period !== want) begin
                        report_mismatch($sformatf("orbit_period got %0d want %0d",
                                                  i_out_mon.orbit_period, want));
                    end
                end
            end
            if (i_in_mon.valid && i_in_mon.ready) begin
                expected_periods = {expected_periods,
                                    predict_period(i_in_mon.growth_rate)};
            end
            // Publish the outstanding count before the next falling edge
            o_pending = expected_periods.size();
        end
    end

endmodule

[tb/sv/tb_top.sv]
`timescale 1ns / 1ps

module tb_top;
    import lmpd_pkg::*;

    localparam int STALL_LIMIT = 400000;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic psel = 1'b0;
    logic penable = 1'b0;
    logic pwrite = 1'b0;
    logic [PADDR_W-1:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic pready;
    int fail_count;
    int pending;
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int quiet_cycles = 0;

    lmpd_in_if  in_ch();
    lmpd_out_if out_ch();

    logistic_map_period_detector_unit uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_in(in_ch), .o_out(out_ch),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    lmpd_checker checker_i (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_in_mon(in_ch), .i_out_mon(out_ch),
        .i_psel(psel), .i_penable(penable), .i_pwrite(pwrite), .i_pready(pready),
        .i_paddr(paddr), .i_pwdata(pwdata),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    always #5 i_clk = ~i_clk;

    initial begin
        in_ch.valid = 1'b0;
        in_ch.growth_rate = '0;
        out_ch.ready = 1'b0;
    end

    // Result side back-pressure
    always @(negedge i_clk) begin
        out_ch.ready = ($urandom_range(99) >= recv_stall_pct);
    end

    // End the run when nothing moves for too long
    always @(posedge i_clk) begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)
                || (psel && penable)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic write_reg(input t_reg_idx idx, input logic [31:0] value);
        paddr = {idx, 2'b00};
        pwdata = value;
        pwrite = 1'b1;
        psel = 1'b1;
        penable = 1'b0;
        @(negedge i_clk);
        penable = 1'b1;
        do @(posedge i_clk); while (!pready);
        @(negedge i_clk);
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
    endtask

    task automatic set_config(input logic [31:0] ceil, input logic [31:0] steps,
                              input logic [31:0] count, input logic [31:0] gap);
        write_reg(REG_PERIOD_CEILING, ceil);
        write_reg(REG_SETTLE_STEPS, steps);
        write_reg(REG_SAMPLE_COUNT, count);
        write_reg(REG_CLUSTER_GAP, gap);
    endtask

    // Hold until every result is back, then let the block settle
    task automatic drain();
        while (pending != 0) @(negedge i_clk);
        repeat (10) @(negedge i_clk);
    endtask

    task automatic send_rate(input logic [31:0] r);
        while ($urandom_range(99) < send_idle_pct) @(negedge i_clk);
        in_ch.valid = 1'b1;
        in_ch.growth_rate = r;
        do @(posedge i_clk); while (!in_ch.ready);
        @(negedge i_clk);
        in_ch.valid = 1'b0;
    endtask

    // Mostly rates in the period-doubling region, some anywhere
    function automatic logic [31:0] pick_rate();
        if ($urandom_range(99) < 65) begin
            return $urandom_range(32'hE600_0000, 32'hA000_0000);
        end
        return $urandom();
    endfunction

    task automatic random_config();
        logic [31:0] gap;
        case ($urandom_range(3))
            0: gap = GAP_RST;
            1: gap = $urandom_range(32'h0100_0000);
            2: gap = $urandom();
            default: gap = $urandom_range(200);
        endcase
        set_config(($urandom_range(9) == 0) ? 127 : $urandom_range(12, 1),
                   $urandom_range(300), $urandom_range(24, 1), gap);
    endtask

    initial begin
        logic [31:0] directed_rates[8];
        directed_rates = '{32'h0000_0000, 32'hFFFF_FFFF, 32'h4000_0000, 32'hC000_0000,
                           32'hD000_0000, 32'hE000_0000, 32'hE400_0000, 32'hE800_0000};
        repeat (7) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        // Directed: rate extremes and the doubling cascade
        set_config(64, 100, 16, GAP_RST);
        foreach (directed_rates[k]) send_rate(directed_rates[k]);
        drain();
        // No samples at all
        write_reg(REG_SAMPLE_COUNT, 0);
        send_rate(32'hE800_0000);
        drain();
        // Count beyond the store saturates; full store with no settling
        set_config(64, 0, 2047, GAP_RST);
        send_rate(32'h0000_0000);
        drain();
        write_reg(REG_SAMPLE_COUNT, 1024);
        send_rate(32'h0000_0000);
        drain();
        // Zero ceiling hides every count
        set_config(0, 100, 16, GAP_RST);
        send_rate(32'hE000_0000);
        send_rate(32'hE400_0000);
        drain();
        // Widest ceiling with zero gap, then the largest gap
        set_config(127, 50, 32, 0);
        send_rate(32'hE800_0000);
        send_rate(32'hFFFF_FFFF);
        drain();
        write_reg(REG_CLUSTER_GAP, 32'hFFFF_FFFF);
        send_rate(32'hE800_0000);
        drain();
        // Long settling
        set_config(64, 5000, 4, GAP_RST);
        send_rate(32'hD000_0000);
        send_rate(32'hE400_0000);
        drain();

        // Random phases across idling patterns
        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 86; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 86; end
                default: begin send_idle_pct = 13; recv_stall_pct = 13; end
            endcase
            for (int blk = 0; blk < 3; blk++) begin
                random_config();
                for (int k = 0; k < 7; k++) begin
                    send_rate(pick_rate());
                    // Let the pipeline empty out before carrying on
                    if (phase == 0 && blk == 0 && k == 4) begin
                        while (pending != 0) @(negedge i_clk);
                    end
                end
                drain();
            end
        end

        repeat (50) @(negedge i_clk);
        if (fail_count == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
